[hw/rtl/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

    // Pattern and replacement limits, window and per-beat result limits
    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int WIN_DEPTH   = 8;
    localparam int OUT_LIMIT   = 8;

    // APB register map: 64-bit registers at byte address 8*i
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam logic [1:0] REG_SEARCH_BYTES  = 2'd0;
    localparam logic [1:0] REG_SEARCH_COUNT  = 2'd1;
    localparam logic [1:0] REG_REPLACE_BYTES = 2'd2;
    localparam logic [1:0] REG_REPLACE_COUNT = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_last;
        logic       text_end;
    } result_out_t;

    typedef struct packed {
        logic [63:0] search_bytes;
        logic [3:0]  search_count;
        logic [63:0] replace_bytes;
        logic [3:0]  replace_count;
    } cfg_t;

    typedef logic [OUT_LIMIT-1:0][7:0] byte_row_t;

    // Control handed from the step logic to the result buffer
    typedef struct packed {
        logic       load;
        logic [3:0] count;
        logic       empty;
        logic       text_end;
    } res_load_t;

endpackage

`default_nettype wire

[hw/rtl/sfr_regs.sv]
`default_nettype none

module sfr_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic      [sfr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output sfr_pkg::cfg_t                   cfg
);

    sfr_pkg::cfg_t cfg_reg;
    sfr_pkg::cfg_t cfg_next;
    logic [1:0]    reg_idx;

    assign reg_idx = paddr[4:3];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Decode a completed write beat into the register file
    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (reg_idx)
                sfr_pkg::REG_SEARCH_BYTES:  cfg_next.search_bytes  = pwdata;
                sfr_pkg::REG_SEARCH_COUNT:  cfg_next.search_count  = pwdata[3:0];
                sfr_pkg::REG_REPLACE_BYTES: cfg_next.replace_bytes = pwdata;
                sfr_pkg::REG_REPLACE_COUNT: cfg_next.replace_count = pwdata[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.search_bytes  <= '0;
            cfg_reg.search_count  <= 4'd1;
            cfg_reg.replace_bytes <= '0;
            cfg_reg.replace_count <= 4'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            sfr_pkg::REG_SEARCH_BYTES:  prdata = cfg_reg.search_bytes;
            sfr_pkg::REG_SEARCH_COUNT:  prdata = {60'd0, cfg_reg.search_count};
            sfr_pkg::REG_REPLACE_BYTES: prdata = cfg_reg.replace_bytes;
            sfr_pkg::REG_REPLACE_COUNT: prdata = {60'd0, cfg_reg.replace_count};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/sfr_step.sv]
`default_nettype none

module sfr_step #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire sfr_pkg::text_in_t     s_data,
    input  wire sfr_pkg::cfg_t         cfg,
    output sfr_pkg::res_load_t         res_ctl,
    output sfr_pkg::byte_row_t         res_bytes
);

    sfr_pkg::byte_row_t win_reg;
    sfr_pkg::byte_row_t win_next;
    logic [2:0]         fill_reg;
    logic [2:0]         fill_next;

    sfr_pkg::byte_row_t ext;
    sfr_pkg::byte_row_t shifted;
    logic [3:0]         pat;
    logic [3:0]         rep;
    logic [3:0]         nf;
    logic               do_cmp;
    logic               match;
    logic [3:0]         drop;
    logic [3:0]         keep;
    logic [3:0]         n0;
    logic [4:0]         total;
    logic [3:0]         src;

    // Effective pattern and replacement lengths
    always_comb begin
        if (cfg.search_count == 4'd0)
            pat = 4'd1;
        else if (cfg.search_count > 4'(MAX_PATTERN))
            pat = 4'(MAX_PATTERN);
        else
            pat = cfg.search_count;
        if (cfg.replace_count > 4'(MAX_REPLACE))
            rep = 4'(MAX_REPLACE);
        else
            rep = cfg.replace_count;
    end

    // Append the beat, compare, and work out what leaves the window
    always_comb begin
        ext           = win_reg;
        ext[fill_reg] = s_data.text_byte;
        nf            = {1'b0, fill_reg} + 4'd1;
        do_cmp        = (nf >= pat);
        match         = 1'b1;
        for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++) begin
            if ((4'(i) < pat) && (ext[i] != cfg.search_bytes[8*i +: 8]))
                match = 1'b0;
        end
        if (!do_cmp) begin
            drop = 4'd0;
            n0   = 4'd0;
        end else if (match) begin
            drop = pat;
            n0   = rep;
        end else begin
            drop = 4'd1;
            n0   = 4'd1;
        end
        keep = nf - drop;
        for (int j = 0; j < sfr_pkg::WIN_DEPTH; j++) begin
            src = 4'(j) + drop;
            shifted[j] = (src < 4'(sfr_pkg::WIN_DEPTH)) ? ext[src[2:0]] : 8'd0;
        end
    end

    // Build the result row: replacement or oldest byte, then flushed bytes
    always_comb begin
        for (int k = 0; k < sfr_pkg::OUT_LIMIT; k++) begin
            if (4'(k) < n0)
                res_bytes[k] = match ? cfg.replace_bytes[8*k +: 8] : ext[0];
            else
                res_bytes[k] = shifted[3'(4'(k) - n0)];
        end
        total = {1'b0, n0} + {1'b0, keep};
        res_ctl.load     = accept;
        res_ctl.text_end = s_data.text_last;
        res_ctl.empty    = 1'b0;
        if (s_data.text_last) begin
            if (total == 5'd0) begin
                res_ctl.count = 4'd1;
                res_ctl.empty = 1'b1;
            end else if (total > 5'(sfr_pkg::OUT_LIMIT)) begin
                res_ctl.count = 4'(sfr_pkg::OUT_LIMIT);
            end else begin
                res_ctl.count = total[3:0];
            end
        end else begin
            res_ctl.count = n0;
        end
    end

    // Advance the window; end of text leaves it empty
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (accept) begin
            win_next  = shifted;
            fill_next = s_data.text_last ? 3'd0 : keep[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 3'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sfr_outbuf.sv]
`default_nettype none

module sfr_outbuf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sfr_pkg::res_load_t res_ctl,
    input  wire sfr_pkg::byte_row_t res_bytes,
    output logic                    free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sfr_pkg::result_out_t    m_data
);

    sfr_pkg::byte_row_t bytes_reg;
    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    logic [3:0]         cnt_reg;
    logic               valid_reg;
    logic               valid_next;
    logic               empty_reg;
    logic               end_reg;
    logic               last_beat;

    assign last_beat = (({1'b0, idx_reg} + 4'd1) == cnt_reg);
    assign free      = !valid_reg || (m_ready && last_beat);
    assign m_valid   = valid_reg;

    // Present the current beat of the run
    always_comb begin
        m_data.out_byte     = empty_reg ? 8'd0 : bytes_reg[idx_reg];
        m_data.byte_present = !empty_reg;
        m_data.run_last     = last_beat;
        m_data.text_end     = end_reg && last_beat;
    end

    // Pop one beat per transfer, reload when a new run arrives
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            if (last_beat)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
        if (res_ctl.load) begin
            idx_next   = 3'd0;
            valid_next = (res_ctl.count != 4'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ctl.load) begin
            bytes_reg <= res_bytes;
            cnt_reg   <= res_ctl.count;
            empty_reg <= res_ctl.empty;
            end_reg   <= res_ctl.text_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stream_find_replace_unit.sv]
// Streaming search and replace-all over a byte stream.
// Input channel (s_valid/s_ready/s_data): one text byte per beat, with
// text_last on the final byte of a text. Result channel (m_valid/m_ready/
// m_data): edited bytes in order, run_last on the final beat caused by an
// input byte, text_end on the final beat of a text; a text whose tail yields
// nothing ends with one beat that has byte_present low.
// Configuration: APB port, 64-bit registers at byte address 8*i (search
// bytes, search count, replacement bytes, replacement count); write only
// while no text byte is in flight.
// A result beat appears in the cycle after the input beat causing it. An
// input byte yielding several beats holds the input while the result
// buffer drains one beat per cycle as m_ready allows; bytes yielding zero
// or one beat flow at one per cycle while m_ready is high, accepted as the
// previous beat is taken. Reset empties the window and result buffer and
// restores search count 1, replacement count 0. When m_ready is low the
// pending run holds; s_ready drops once the buffer cannot take the next run.
`default_nettype none

module stream_find_replace_unit #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire sfr_pkg::text_in_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output sfr_pkg::result_out_t            m_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic      [sfr_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    sfr_pkg::cfg_t      cfg;
    sfr_pkg::res_load_t res_ctl;
    sfr_pkg::byte_row_t res_bytes;
    logic               free;
    logic               accept;

    assign s_ready = free;
    assign accept  = s_valid && free;

    sfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_step #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .s_data    (s_data),
        .cfg       (cfg),
        .res_ctl   (res_ctl),
        .res_bytes (res_bytes)
    );

    sfr_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_ctl   (res_ctl),
        .res_bytes (res_bytes),
        .free      (free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

[verif/sfr_edit_checker.sv]
`timescale 1ns / 1ps

module sfr_edit_checker
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  text_in_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  result_out_t       m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                fail_count,
    output int                pending_edits
);

    // Shadow copy of the configuration registers
    logic [63:0] find_bytes;
    logic [3:0]  find_count;
    logic [63:0] subst_bytes;
    logic [3:0]  subst_count;

    // Bytes starting at the current candidate position
    logic [7:0]  window [WIN_DEPTH];
    int          window_fill;

    result_out_t beat_edits[$];
    result_out_t edits_due[$];
    result_out_t want;
    int          mismatches = 0;
    int          due_count = 0;

    assign fail_count    = mismatches;
    assign pending_edits = due_count;

    // Append one edited byte, capped at the per-beat result limit
    function void add_edit(logic [7:0] b, logic present);
        result_out_t e;
        if (beat_edits.size() >= OUT_LIMIT) begin
            return;
        end
        e = '{out_byte: b, byte_present: present, run_last: 1'b0, text_end: 1'b0};
        beat_edits.push_back(e);
    endfunction

    // Drop the k oldest bytes from the window
    function void slide_window(int k);
        int i;
        if (k >= window_fill) begin
            window_fill = 0;
        end else begin
            for (i = 0; i + k < window_fill; i++) begin
                window[i] = window[i + k];
            end
            window_fill -= k;
        end
    endfunction

    // Work out the edited bytes that one text beat causes
    function void predict_edits(text_in_t beat);
        int  plen;
        int  rlen;
        int  i;
        logic same;
        plen = (find_count == 0) ? 1 : ((find_count > MAX_PATTERN) ? MAX_PATTERN : find_count);
        rlen = (subst_count > MAX_REPLACE) ? MAX_REPLACE : subst_count;
        beat_edits.delete();

        if (window_fill < WIN_DEPTH) begin
            window[window_fill] = beat.text_byte;
            window_fill++;
        end

        // At most one compare per beat: match emits the replacement, else the oldest byte
        if (window_fill >= plen) begin
            same = 1'b1;
            for (i = 0; i < plen; i++) begin
                if (window[i] != find_bytes[8*i +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                for (i = 0; i < rlen; i++) begin
                    add_edit(subst_bytes[8*i +: 8], 1'b1);
                end
                slide_window(plen);
            end else begin
                add_edit(window[0], 1'b1);
                slide_window(1);
            end
        end

        // Flush pending bytes at end of text; mark an empty ending
        if (beat.text_last) begin
            for (i = 0; i < window_fill; i++) begin
                add_edit(window[i], 1'b1);
            end
            window_fill = 0;
            if (beat_edits.size() == 0) begin
                add_edit(8'h00, 1'b0);
            end
            beat_edits[beat_edits.size() - 1].text_end = 1'b1;
        end

        if (beat_edits.size() > 0) begin
            beat_edits[beat_edits.size() - 1].run_last = 1'b1;
        end
        foreach (beat_edits[k]) begin
            edits_due.push_back(beat_edits[k]);
        end
    endfunction

    function void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Follow register writes, predict on input beats, compare result beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            find_bytes  = '0;
            find_count  = 4'd1;
            subst_bytes = '0;
            subst_count = 4'd0;
            window_fill = 0;
            foreach (window[i]) begin
                window[i] = 8'h00;
            end
            edits_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:3])
                    REG_SEARCH_BYTES:  find_bytes  = pwdata;
                    REG_SEARCH_COUNT:  find_count  = pwdata[3:0];
                    REG_REPLACE_BYTES: subst_bytes = pwdata;
                    REG_REPLACE_COUNT: subst_count = pwdata[3:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                predict_edits(s_data);
            end

            if (m_valid && m_ready) begin
                if (edits_due.size() == 0) begin
                    $error("unexpected result beat, out_byte %0h", m_data.out_byte);
                    mismatches++;
                end else begin
                    want = edits_due.pop_front();
                    check_field("out_byte", want.out_byte, m_data.out_byte);
                    check_field("byte_present", want.byte_present, m_data.byte_present);
                    check_field("run_last", want.run_last, m_data.run_last);
                    check_field("text_end", want.text_end, m_data.text_end);
                end
            end
        end
        due_count = edits_due.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    text_in_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    result_out_t       m_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_edits;

    // Stimulus-side view of the current pattern
    logic [63:0] pat_bytes;
    int          pat_len;
    logic [3:0]  pat_count;

    logic [7:0]  text_q[$];
    bit          valid_up = 1'b0;
    int          burst_left = 0;
    int          gap;
    int          phase_items;
    int          text_len;
    int          m;
    int          k;
    int          stall_left = 0;
    int          stall_mode = 0;

    always #5 aclk = ~aclk;

    stream_find_replace_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfr_edit_checker u_edit_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_edits (pending_edits)
    );

    // Receiver: switch between always ready, light stalls and heavy stalls
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic apb_write(logic [1:0] idx, logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pattern(logic [63:0] bytes, logic [3:0] cnt);
        pat_bytes = bytes;
        pat_count = cnt;
        pat_len   = (cnt == 0) ? 1 : ((cnt > MAX_PATTERN) ? MAX_PATTERN : cnt);
        apb_write(REG_SEARCH_BYTES, bytes);
        apb_write(REG_SEARCH_COUNT, {60'd0, cnt});
    endtask

    task automatic set_replacement(logic [63:0] bytes, logic [3:0] cnt);
        apb_write(REG_REPLACE_BYTES, bytes);
        apb_write(REG_REPLACE_COUNT, {60'd0, cnt});
    endtask

    // Present one text beat and hold it until accepted; sometimes idle between bursts
    task automatic text_beat(logic [7:0] b, logic last);
        s_valid  <= 1'b1;
        s_data   <= '{text_byte: b, text_last: last};
        valid_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid  <= 1'b0;
                s_data   <= '{text_byte: 8'($urandom_range(0, 255)), text_last: 1'($urandom)};
                valid_up = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_text(bit close);
        foreach (text_q[i]) begin
            text_beat(text_q[i], close && (i == text_q.size() - 1));
        end
        phase_items += text_q.size();
    endtask

    // Hold the sender until every expected result has come, then settle
    task automatic wait_for_edits(int settle);
        if (valid_up) begin
            s_valid  <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge aclk);
        while (pending_edits != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    initial begin
        pat_bytes = '0;
        pat_count = 4'd1;
        pat_len   = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: single zero byte is deleted; empty ending
        text_q = '{8'h00};
        send_text(1'b0);
        text_q = '{8'hFF};
        send_text(1'b1);
        text_q = '{8'h00};
        send_text(1'b1);
        wait_for_edits(4);

        // Two-byte pattern, longest replacement of all ones
        set_pattern(64'h4241, 4'd2);
        set_replacement({64{1'b1}}, 4'd8);
        text_q = '{8'h41, 8'h42, 8'h41, 8'h41, 8'h42};
        send_text(1'b1);
        wait_for_edits(4);

        // Zero search length acts as one; oversized replacement count
        set_pattern(64'h00000000000000FF, 4'd0);
        set_replacement(64'h0123456789ABCDEF, 4'd15);
        text_q = '{8'hFF, 8'h00, 8'hFF};
        send_text(1'b1);
        wait_for_edits(4);

        // Oversized search count acts as eight, then shrink with bytes pending
        set_pattern(64'h8877665544332211, 4'd15);
        set_replacement(64'h00000000000000A5, 4'd1);
        text_q = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
        send_text(1'b0);
        text_q = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
        send_text(1'b0);
        wait_for_edits(4);
        set_pattern(64'h8877665544332211, 4'd1);
        set_replacement(64'h5A4B3C2D1E0F0718, 4'd8);
        text_q = '{8'h99};
        send_text(1'b1);
        wait_for_edits(4);

        // Random phases: texts built mostly from pattern pieces
        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                set_pattern({$urandom, $urandom}, 4'd8);
                set_replacement({64{1'b1}}, 4'd8);
            end else if (p == 1) begin
                set_pattern(64'd0, 4'd1);
                set_replacement(64'd0, 4'd0);
            end else begin
                case ($urandom_range(0, 7))
                    0:       pat_count = 4'd0;
                    1:       pat_count = 4'($urandom_range(9, 15));
                    2:       pat_count = 4'd8;
                    default: pat_count = 4'($urandom_range(1, 4));
                endcase
                if ($urandom_range(0, 1)) begin
                    for (k = 0; k < 8; k++) begin
                        pat_bytes[8*k +: 8] = 8'($urandom_range(65, 68));
                    end
                end else begin
                    pat_bytes = {$urandom, $urandom};
                end
                set_pattern(pat_bytes, pat_count);
                set_replacement({$urandom, $urandom}, 4'($urandom_range(0, 15)));
            end

            phase_items = 0;
            while (phase_items < 36) begin
                text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 10);
                text_q.delete();
                while (text_q.size() < text_len) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            for (k = 0; k < pat_len; k++) begin
                                text_q.push_back(pat_bytes[8*k +: 8]);
                            end
                        end
                        4, 5: begin
                            // Broken occurrence: a prefix, sometimes with a wrong tail
                            m = $urandom_range(1, pat_len);
                            for (k = 0; k < m; k++) begin
                                text_q.push_back(pat_bytes[8*k +: 8]);
                            end
                            if ($urandom_range(0, 1)) begin
                                text_q[text_q.size() - 1] = text_q[text_q.size() - 1]
                                                            ^ 8'($urandom_range(1, 255));
                            end
                        end
                        6, 7:    text_q.push_back(pat_bytes[8*$urandom_range(0, 7) +: 8]);
                        default: text_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                send_text(1'b1);
                if ($urandom_range(0, 5) == 0) begin
                    wait_for_edits(0);
                end
            end
            wait_for_edits(4);
        end

        // Final drain with a bound, then the verdict
        for (k = 0; k < 20000 && pending_edits != 0; k++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_edits != 0) begin
            $error("%0d expected result beats never arrived", pending_edits);
        end
        if (fail_count == 0 && pending_edits == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_regs.sv
hw/rtl/sfr_step.sv
hw/rtl/sfr_outbuf.sv
hw/rtl/stream_find_replace_unit.sv
verif/sfr_edit_checker.sv
verif/tb.sv
